// ===== rtl/stm_pkg.sv =====
`timescale 1ns / 1ps

package stm_pkg;

  // Fixed field widths of the request, result and configuration items.
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned TOT_W      = 32;
  localparam int unsigned FIX_W      = 48;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned WGT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic             ENABLE_RST = 1'b1;
  localparam logic [WGT_W-1:0] SMOOTH_RST = 16'd3932;
  localparam logic [WGT_W-1:0] DECAY_RST  = 16'd63570;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_SMOOTH = 2'd1,
    CFG_DECAY  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FDIFF,
    ST_FMUL,
    ST_FADD,
    ST_ROT,
    ST_EMPTY
  } state_e;

  // One section slot as it travels along the cell chain.
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [TOT_W-1:0] total;
    logic [FIX_W-1:0] avg;
    logic [FIX_W-1:0] peak;
  } slot_t;

  // Tick count to fixed point, saturating at the top of the fixed-point range.
  function automatic logic [FIX_W-1:0] to_fixed(input logic [TS_W-1:0] t,
                                                input int unsigned frac);
    logic [TS_W-1:0] upper;
    logic [TS_W-1:0] shifted;
    upper   = t >> (FIX_W - frac);
    shifted = t << frac;
    if (upper != '0) begin
      return '1;
    end
    return shifted[FIX_W-1:0];
  endfunction

  // Multiply by an unsigned 16-bit fraction, truncated.
  function automatic logic [FIX_W-1:0] frac_mul(input logic [FIX_W-1:0] a,
                                                input logic [WGT_W-1:0] w);
    logic [FIX_W+WGT_W-1:0] p;
    p = (FIX_W+WGT_W)'(a) * (FIX_W+WGT_W)'(w);
    return p[FIX_W+WGT_W-1:WGT_W];
  endfunction

endpackage

// ===== rtl/section_time_monitor.sv =====
// Section time monitor.
// Input channel (in_valid_i / in_stall_o): a request with cmd_i add carries a
// section key and a duration in ticks; it is absorbed as it is taken, so add
// requests stream at one per cycle while in_stall_o is low. A request with
// cmd_i frame carries a timestamp; it updates the smoothed frame time in the
// states ST_FDIFF, ST_FMUL and ST_FADD, then the slot chain rotates once
// through the shared update unit, NUM_SECTIONS + 2 steps, so a frame request
// holds the input until the rotation ends, plus any output stall. With no
// section stored a single empty result follows the frame update instead.
// Output channel (out_valid_o / out_stall_i): one result per stored section
// in slot order, the final one flagged by last_o. A result sits in an output
// register; while the receiver stalls the chain simply stops advancing.
// Configuration writes (cfg_we_i) are taken at any edge and meant for idle.
// Reset clears all slots, the frame history and the overflow flag, and loads
// the register defaults: enabled, weight 3932 and decay 63570 in Q.16.
`timescale 1ns / 1ps

module section_time_monitor #(
  parameter int unsigned NUM_SECTIONS = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [stm_pkg::KEY_W-1:0]      section_key_i,
  input  logic [stm_pkg::TOT_W-1:0]      duration_i,
  input  logic [stm_pkg::TS_W-1:0]       timestamp_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           has_section_o,
  output logic [stm_pkg::KEY_W-1:0]      key_out_o,
  output logic [stm_pkg::TOT_W-1:0]      frame_total_o,
  output logic [stm_pkg::FIX_W-1:0]      average_out_o,
  output logic [stm_pkg::FIX_W-1:0]      peak_out_o,
  output logic [stm_pkg::FIX_W-1:0]      frame_average_out_o,
  output logic                           overflowed_o,
  output logic                           last_o
);
  import stm_pkg::*;

  localparam int unsigned       CNT_W     = $clog2(NUM_SECTIONS + 1);
  localparam int unsigned       STEP_W    = $clog2(NUM_SECTIONS + 2);
  localparam logic [STEP_W-1:0] LastStep  = STEP_W'(NUM_SECTIONS + 1);
  localparam logic [CNT_W-1:0]  FullCount = CNT_W'(NUM_SECTIONS);

  state_e state_q, state_d;

  // Configuration registers.
  logic             enable_q;
  logic [WGT_W-1:0] smooth_q, decay_q;

  // Frame timing state.
  logic [TS_W-1:0]  start_q;
  logic             started_q, had_start_q;
  logic [FIX_W-1:0] fx_q, fdiff_q, fstep_q, fa_q;
  logic             fge_q;
  logic             ovf_q;

  logic [CNT_W-1:0]  count_q;
  logic [STEP_W-1:0] step_q;

  // Output register.
  logic             out_valid_q;
  logic             out_has_q, out_last_q, out_ovf_q;
  logic [KEY_W-1:0] out_key_q;
  logic [TOT_W-1:0] out_total_q;
  logic [FIX_W-1:0] out_avg_q, out_peak_q, out_fa_q;

  // Handshake and control decode.
  logic in_accept, add_go, frame_go, any_hit, claim_ok, ovf_set;
  logic out_free, adv, emit, emit_last, empty_go;

  // Slot chain: cell 0 feeds the update unit, whose result re-enters at the top.
  slot_t                   cell_data [NUM_SECTIONS];
  slot_t                   shift_in  [NUM_SECTIONS];
  logic [NUM_SECTIONS-1:0] prev_used;
  logic [NUM_SECTIONS-1:0] hit;
  slot_t                   res, tail_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign add_go     = in_accept && enable_q && (cmd_i == CMD_ADD);
  assign frame_go   = in_accept && enable_q && (cmd_i == CMD_FRAME);
  assign any_hit    = |hit;
  assign claim_ok   = add_go && !any_hit && (count_q != FullCount);
  assign ovf_set    = add_go && !any_hit && (count_q == FullCount);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign adv       = (state_q == ST_ROT) && out_free;
  assign emit      = adv && res.used;
  // The two pipeline bubbles leave first, so slot k comes out at step k + 2.
  assign emit_last = (step_q == (STEP_W'(count_q) + STEP_W'(1)));
  assign empty_go  = (state_q == ST_EMPTY) && out_free;

  always_comb begin
    tail_data       = res;
    tail_data.total = '0;
  end

  for (genvar i = 0; i < NUM_SECTIONS; i++) begin : g_cell
    if (i == NUM_SECTIONS - 1) begin : g_top
      assign shift_in[i] = tail_data;
    end else begin : g_mid
      assign shift_in[i] = cell_data[i+1];
    end
    if (i == 0) begin : g_bottom
      assign prev_used[i] = 1'b1;
    end else begin : g_upper
      assign prev_used[i] = cell_data[i-1].used;
    end

    stm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (adv),
      .shift_data_i(shift_in[i]),
      .add_i       (add_go),
      .key_i       (section_key_i),
      .dur_i       (duration_i),
      .prev_used_i (prev_used[i]),
      .any_hit_i   (any_hit),
      .data_o      (cell_data[i]),
      .hit_o       (hit[i])
    );
  end

  stm_update #(
    .FRAC_BITS(FRAC_BITS)
  ) u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .smooth_i(smooth_q),
    .decay_i (decay_q),
    .slot_i  (cell_data[0]),
    .res_o   (res)
  );

  // Sequencer: frame average update, then a full chain rotation or an empty result.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (frame_go) begin
          state_d = ST_FDIFF;
        end
      end
      ST_FDIFF: state_d = ST_FMUL;
      ST_FMUL:  state_d = ST_FADD;
      ST_FADD: begin
        state_d = (count_q == '0) ? ST_EMPTY : ST_ROT;
      end
      ST_ROT: begin
        if (adv && (step_q == LastStep)) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= ENABLE_RST;
      smooth_q <= SMOOTH_RST;
      decay_q  <= DECAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_SMOOTH: smooth_q <= cfg_data_i[WGT_W-1:0];
        CFG_DECAY:  decay_q  <= cfg_data_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state and the values that reset defines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      started_q   <= 1'b0;
      fa_q        <= '0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (frame_go) begin
        start_q   <= timestamp_i;
        started_q <= 1'b1;
      end
      if ((state_q == ST_FADD) && had_start_q) begin
        fa_q <= fge_q ? (fa_q + fstep_q) : (fa_q - fstep_q);
      end
      if (ovf_set) begin
        ovf_q <= 1'b1;
      end
      if (claim_ok) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (state_q == ST_FADD) begin
        step_q <= '0;
      end else if (adv) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (emit || empty_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame delta pipeline: wrap-around difference, then distance, then weight.
  always_ff @(posedge clk_i) begin
    if (frame_go) begin
      fx_q        <= to_fixed(timestamp_i - start_q, FRAC_BITS);
      had_start_q <= started_q;
    end
    if (state_q == ST_FDIFF) begin
      fge_q   <= fx_q >= fa_q;
      fdiff_q <= (fx_q >= fa_q) ? (fx_q - fa_q) : (fa_q - fx_q);
    end
    if (state_q == ST_FMUL) begin
      fstep_q <= frac_mul(fdiff_q, smooth_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_has_q   <= 1'b1;
      out_key_q   <= res.key;
      out_total_q <= res.total;
      out_avg_q   <= res.avg;
      out_peak_q  <= res.peak;
      out_fa_q    <= fa_q;
      out_ovf_q   <= ovf_q;
      out_last_q  <= emit_last;
    end else if (empty_go) begin
      out_has_q   <= 1'b0;
      out_key_q   <= '0;
      out_total_q <= '0;
      out_avg_q   <= '0;
      out_peak_q  <= '0;
      out_fa_q    <= fa_q;
      out_ovf_q   <= ovf_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign has_section_o       = out_has_q;
  assign key_out_o           = out_key_q;
  assign frame_total_o       = out_total_q;
  assign average_out_o       = out_avg_q;
  assign peak_out_o          = out_peak_q;
  assign frame_average_out_o = out_fa_q;
  assign overflowed_o        = out_ovf_q;
  assign last_o              = out_last_q;

endmodule

// ===== rtl/stm_cell.sv =====
`timescale 1ns / 1ps

module stm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  stm_pkg::slot_t            shift_data_i,
  input  logic                      add_i,
  input  logic [stm_pkg::KEY_W-1:0] key_i,
  input  logic [stm_pkg::TOT_W-1:0] dur_i,
  input  logic                      prev_used_i,
  input  logic                      any_hit_i,
  output stm_pkg::slot_t            data_o,
  output logic                      hit_o
);
  import stm_pkg::*;

  logic             used_q, used_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [FIX_W-1:0] avg_q, avg_d;
  logic [FIX_W-1:0] peak_q, peak_d;
  logic [TOT_W:0]   sum;
  logic             claim;

  assign hit_o = used_q && (key_q == key_i);
  // Slots fill from the bottom, so the first free cell sits just above a used one.
  assign claim = add_i && !any_hit_i && !used_q && prev_used_i;
  assign sum   = {1'b0, total_q} + {1'b0, dur_i};

  always_comb begin
    used_d  = used_q;
    key_d   = key_q;
    total_d = total_q;
    avg_d   = avg_q;
    peak_d  = peak_q;
    priority if (shift_i) begin
      used_d  = shift_data_i.used;
      key_d   = shift_data_i.key;
      total_d = shift_data_i.total;
      avg_d   = shift_data_i.avg;
      peak_d  = shift_data_i.peak;
    end else if (add_i && hit_o) begin
      total_d = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
    end else if (claim) begin
      used_d  = 1'b1;
      key_d   = key_i;
      total_d = dur_i;
      avg_d   = '0;
      peak_d  = '0;
    end else begin
      used_d  = used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    total_q <= total_d;
    avg_q   <= avg_d;
    peak_q  <= peak_d;
  end

  assign data_o = '{used: used_q, key: key_q, total: total_q, avg: avg_q, peak: peak_q};

endmodule

// ===== rtl/stm_update.sv =====
`timescale 1ns / 1ps

module stm_update #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [stm_pkg::WGT_W-1:0] smooth_i,
  input  logic [stm_pkg::WGT_W-1:0] decay_i,
  input  stm_pkg::slot_t            slot_i,
  output stm_pkg::slot_t            res_o
);
  import stm_pkg::*;

  // First stage: fixed-point total, distance to the average, decayed peak.
  logic [FIX_W-1:0] x_a, diff_a, pdec_a;
  logic             ge_a;

  assign x_a    = to_fixed(TS_W'(slot_i.total), FRAC_BITS);
  assign ge_a   = x_a >= slot_i.avg;
  assign diff_a = ge_a ? (x_a - slot_i.avg) : (slot_i.avg - x_a);
  assign pdec_a = frac_mul(slot_i.peak, decay_i);

  logic             s1_used_q;
  slot_t            s1_slot_q;
  logic [FIX_W-1:0] s1_x_q, s1_diff_q, s1_pdec_q;
  logic             s1_ge_q;

  logic             s2_used_q;
  slot_t            s2_slot_q;
  logic [FIX_W-1:0] s2_x_q, s2_step_q, s2_pdec_q;
  logic             s2_ge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_used_q <= 1'b0;
      s2_used_q <= 1'b0;
    end else if (adv_i) begin
      s1_used_q <= slot_i.used;
      s2_used_q <= s1_used_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_slot_q <= slot_i;
      s1_x_q    <= x_a;
      s1_ge_q   <= ge_a;
      s1_diff_q <= diff_a;
      s1_pdec_q <= pdec_a;
      s2_slot_q <= s1_slot_q;
      s2_x_q    <= s1_x_q;
      s2_ge_q   <= s1_ge_q;
      s2_step_q <= frac_mul(s1_diff_q, smooth_i);
      s2_pdec_q <= s1_pdec_q;
    end
  end

  // Final step: move the average toward the sample, hold the larger peak.
  always_comb begin
    res_o       = s2_slot_q;
    res_o.used  = s2_used_q;
    res_o.avg   = s2_ge_q ? (s2_slot_q.avg + s2_step_q) : (s2_slot_q.avg - s2_step_q);
    res_o.peak  = (s2_x_q > s2_pdec_q) ? s2_x_q : s2_pdec_q;
  end

endmodule

// ===== rtl/stm_checker.sv =====
`timescale 1ns / 1ps

module stm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      has_section_o,
  input logic [stm_pkg::KEY_W-1:0] key_out_o,
  input logic [stm_pkg::TOT_W-1:0] frame_total_o,
  input logic [stm_pkg::FIX_W-1:0] average_out_o,
  input logic [stm_pkg::FIX_W-1:0] peak_out_o,
  input logic                      overflowed_o,
  input logic                      last_o
);

  logic ovf_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && overflowed_o) begin
      ovf_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_section_o |-> last_o && (key_out_o == '0) &&
      (frame_total_o == '0) && (average_out_o == '0) && (peak_out_o == '0))
    else $error("empty result is not a lone final result with cleared fields");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ovf_seen_q |-> overflowed_o)
    else $error("overflow flag dropped after it was reported");

  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("new request taken before a frame finished reporting");

endmodule

bind section_time_monitor stm_checker u_stm_checker (.*);
